/* sv/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 message hasher.
// No dependencies; imported by every module of the block.
package sha256_pkg;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_BYTE_START = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Round constants
    localparam logic [31:0] SHA_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Initial hash value
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Commands to the round core
    typedef struct packed {
        logic init;   // reload initial hash value
        logic start;  // copy hash value into working variables
        logic round;  // one compression round
        logic fold;   // add working variables into hash value
    } core_ctrl_t;

    // Commands to the block buffer / schedule
    typedef struct packed {
        logic       wr_en;
        logic       shift;
        logic [5:0] wr_idx;
        logic [7:0] wr_byte;
    } sched_ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] rnd_rot_a(input logic [31:0] x);
        rnd_rot_a = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] rnd_rot_e(input logic [31:0] x);
        rnd_rot_e = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sched_rot_lo(input logic [31:0] x);
        sched_rot_lo = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sched_rot_hi(input logic [31:0] x);
        sched_rot_hi = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* sv/sha256_sched.sv */
// Block buffer and message schedule: 16 words filled byte by byte, then
// shifted once per round to produce W_t. Depends on sha256_pkg.
module sha256_sched (
    input  logic                    aclk,
    input  sha256_pkg::sched_ctrl_t sched_ctrl,
    output logic [31:0]             w_cur
);
    import sha256_pkg::*;

    logic [3:0][7:0] win_reg [16];
    logic [31:0]     w_new;
    logic [1:0]      lane;

    assign lane  = 2'd3 - sched_ctrl.wr_idx[1:0];
    assign w_cur = win_reg[0];

    // next schedule word from the sliding window
    assign w_new = sched_rot_hi(win_reg[14]) + win_reg[9]
                 + sched_rot_lo(win_reg[1]) + win_reg[0];

    // byte writes while filling, window shift while compressing
    always_ff @(posedge aclk) begin
        if (sched_ctrl.shift) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end else if (sched_ctrl.wr_en) begin
            win_reg[sched_ctrl.wr_idx[5:2]][lane] <= sched_ctrl.wr_byte;
        end
    end

endmodule

/* sv/sha256_core.sv */
// Round core: hash value and working variables, one SHA-256 round per cycle.
// Depends on sha256_pkg.
module sha256_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha256_pkg::core_ctrl_t core_ctrl,
    input  logic [31:0]            k_in,
    input  logic [31:0]            w_in,
    input  logic [2:0]             rd_idx,
    output logic [31:0]            rd_word
);
    import sha256_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] var_reg  [8];
    logic [31:0] ch, maj, t1, t2;

    // round function
    assign ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
    assign t1  = var_reg[7] + rnd_rot_e(var_reg[4]) + ch + k_in + w_in;
    assign t2  = rnd_rot_a(var_reg[0]) + maj;

    assign rd_word = hash_reg[rd_idx];

    // hash value: initial value on reset or new message, feed-forward add
    always_ff @(posedge aclk) begin
        if (!aresetn || core_ctrl.init) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= SHA_IV[i];
            end
        end else if (core_ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
        end
    end

    // working variables a..h
    always_ff @(posedge aclk) begin
        if (core_ctrl.start) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= hash_reg[i];
            end
        end else if (core_ctrl.round) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule

/* sv/sha256_message_hasher.sv */
// SHA-256 message hasher.
// Input channel (s_): one word per item carries an optional message byte
// (s_byte_valid) and/or an end-of-message mark. Bytes are taken in message
// order. An end mark with no byte finishes the message as it stands; an
// empty message gives the digest of the empty string.
// Output channel (m_): eight 32-bit digest words, index 0 first, with
// m_last_word on the eighth.
// Sequence: a plain byte is written into the buffer. The byte that fills a
// 64-byte block starts its compression (the rounds, one per cycle, in the
// round unit, then a feed-forward add). An end mark writes the padding
// one byte per cycle up to the block end, then compresses that block. Where
// the length needs a fresh block (or the end mark came with the byte that
// filled one), a further block of padding is written and compressed. Then
// the eight digest words are sent.
// s_ready is high only while the block waits for input.
// A stall on m_ready holds the current digest word; nothing else advances.
// Reset (aresetn low, synchronous) loads the initial hash value, clears the
// byte and bit counts and returns to waiting for input. After the last
// digest word the same state is restored for the next message.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        first_reg, first_next;
    logic        extra_reg, extra_next;
    logic        eom_pend_reg, eom_pend_next;
    logic        pad_mode_reg, pad_mode_next;

    core_ctrl_t  core_ctrl;
    sched_ctrl_t sched_ctrl;
    logic [31:0] w_cur;
    logic [5:0]  len_base;
    logic [7:0]  len_byte;
    logic        in_len_area;

    // length byte for buffer positions 56..63, most significant first
    assign len_base    = {3'd7 - cnt_reg[2:0], 3'b000};
    assign len_byte    = bits_reg[len_base +: 8];
    assign in_len_area = (cnt_reg >= 6'(LEN_BYTE_START));

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        bits_next     = bits_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        first_next    = first_reg;
        extra_next    = extra_reg;
        eom_pend_next = eom_pend_reg;
        pad_mode_next = pad_mode_reg;
        core_ctrl     = '0;
        sched_ctrl    = '0;
        sched_ctrl.wr_idx = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_byte_valid) begin
                        sched_ctrl.wr_en   = 1'b1;
                        sched_ctrl.wr_byte = s_msg_byte;
                        cnt_next  = cnt_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (cnt_reg == 6'(BLOCK_BYTES - 1)) begin
                            core_ctrl.start = 1'b1;
                            round_next      = '0;
                            eom_pend_next   = s_end_of_message;
                            state_next      = ST_COMP;
                        end else if (s_end_of_message) begin
                            first_next    = 1'b1;
                            pad_mode_next = 1'b1;
                            state_next    = ST_PAD;
                        end
                    end else if (s_end_of_message) begin
                        first_next    = 1'b1;
                        pad_mode_next = 1'b1;
                        state_next    = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // marker, zero fill, then length in the final block
                sched_ctrl.wr_en = 1'b1;
                if (first_reg) begin
                    sched_ctrl.wr_byte = PAD_MARK;
                    extra_next         = in_len_area;
                end else if (in_len_area && !extra_reg) begin
                    sched_ctrl.wr_byte = len_byte;
                end else begin
                    sched_ctrl.wr_byte = 8'h00;
                end
                first_next = 1'b0;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'(BLOCK_BYTES - 1)) begin
                    core_ctrl.start = 1'b1;
                    round_next      = '0;
                    state_next      = ST_COMP;
                end
            end
            ST_COMP: begin
                core_ctrl.round  = 1'b1;
                sched_ctrl.shift = 1'b1;
                round_next       = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctrl.fold = 1'b1;
                if (pad_mode_reg) begin
                    if (extra_reg) begin
                        extra_next = 1'b0;
                        state_next = ST_PAD;
                    end else begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                end else if (eom_pend_reg) begin
                    eom_pend_next = 1'b0;
                    first_next    = 1'b1;
                    pad_mode_next = 1'b1;
                    state_next    = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        core_ctrl.init = 1'b1;
                        cnt_next       = '0;
                        bits_next      = '0;
                        pad_mode_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            first_reg    <= 1'b0;
            extra_reg    <= 1'b0;
            eom_pend_reg <= 1'b0;
            pad_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            bits_reg     <= bits_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            first_reg    <= first_next;
            extra_reg    <= extra_next;
            eom_pend_reg <= eom_pend_next;
            pad_mode_reg <= pad_mode_next;
        end
    end

    sha256_sched u_sched (
        .aclk       (aclk),
        .sched_ctrl (sched_ctrl),
        .w_cur      (w_cur)
    );

    sha256_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .core_ctrl (core_ctrl),
        .k_in      (SHA_K[round_reg]),
        .w_in      (w_cur),
        .rd_idx    (out_idx_reg),
        .rd_word   (m_digest_word)
    );

endmodule

/* verif/sha256_message_hasher_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sha256_message_hasher: streams byte words, predicts each
// digest with its own SHA-256 model and checks every output word in order.
// Depends on sha256_message_hasher and, through it, sha256_sched, sha256_core and sha256_pkg.
module sha256_message_hasher_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int IDLE_PCT    = 22;
    localparam int RANDOM_BYTES = 120;

    // SHA-256 round constants and starting chain value (FIPS 180-4)
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };
    localparam logic [31:0] START_CHAIN [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LENGTH_FIELD_AT = 56;

    // One input word with its pacing hints
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       ends;
        bit         steady;  // no idle before this word
        bit         drain;   // hold off until all digests are back
    } hash_item_t;

    // One expected digest word
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_msg_byte = 8'h00;
    logic        s_byte_valid = 1'b0;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    hash_item_t   byte_items [$];
    digest_word_t digest_q [$];

    // Predictor state
    logic [31:0] chain_hash [8];
    logic [7:0]  block_bytes [64];
    int          fill_count;
    logic [63:0] len_bits;

    int cycle_count = 0;
    int failures = 0;
    int words_seen = 0;
    int items_taken = 0;
    int bytes_taken = 0;
    int messages_done = 0;
    int blocks_done = 0;
    int random_bytes_queued = 0;
    bit timed_out = 1'b0;
    hash_item_t next_item;

    sha256_message_hasher dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_msg_byte       (s_msg_byte),
        .s_byte_valid     (s_byte_valid),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fresh chain value and empty buffer for the next message
    task automatic restart_chain();
        for (int i = 0; i < 8; i++) chain_hash[i] = START_CHAIN[i];
        fill_count = 0;
        len_bits = '0;
    endtask

    // 64 rounds over the buffered block, folded into the chain value
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
        blocks_done++;
    endtask

    // Absorb one accepted word; an end mark pads, finishes and queues the digest
    task automatic sha_absorb(input logic [7:0] data, input logic has_byte, input logic ends);
        digest_word_t d;
        if (has_byte) begin
            block_bytes[fill_count] = data;
            fill_count = (fill_count + 1) % 64;
            len_bits += 64'd8;
            bytes_taken++;
            if (fill_count == 0) sha_compress();
        end
        if (ends) begin
            block_bytes[fill_count] = PAD_BYTE;
            fill_count++;
            // no room for the length: close this block and pad a fresh one
            if (fill_count > LENGTH_FIELD_AT) begin
                while (fill_count < 64) block_bytes[fill_count++] = 8'h00;
                sha_compress();
                fill_count = 0;
            end
            while (fill_count < LENGTH_FIELD_AT) block_bytes[fill_count++] = 8'h00;
            for (int i = 0; i < 8; i++)
                block_bytes[LENGTH_FIELD_AT + i] = len_bits[63 - 8*i -: 8];
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                d.word  = chain_hash[i];
                d.index = i[2:0];
                d.last  = (i == 7);
                digest_q.push_back(d);
            end
            messages_done++;
            restart_chain();
        end
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Sender may launch the head word this cycle
    function automatic bit can_launch();
        if (byte_items.size() == 0) return 1'b0;
        if (byte_items[0].drain && digest_q.size() != 0) return 1'b0;
        if (byte_items[0].steady) return 1'b1;
        return $urandom_range(99) >= IDLE_PCT;
    endfunction

    // Driver: absorb on handshake, then present the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sha_absorb(s_msg_byte, s_byte_valid, s_end_of_message);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (can_launch()) begin
                    next_item = byte_items.pop_front();
                    s_valid          <= 1'b1;
                    s_msg_byte       <= next_item.data;
                    s_byte_valid     <= next_item.has_byte;
                    s_end_of_message <= next_item.ends;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted digest word against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    note_failure($sformatf("unexpected word %08h index %0d last %0b",
                                           m_digest_word, m_word_index, m_last_word));
                end else begin
                    if (digest_q[0].word !== m_digest_word)
                        note_failure($sformatf("word %0d digest: expected %08h got %08h",
                                               words_seen, digest_q[0].word, m_digest_word));
                    if (digest_q[0].index !== m_word_index)
                        note_failure($sformatf("word %0d index: expected %0d got %0d",
                                               words_seen, digest_q[0].index, m_word_index));
                    if (digest_q[0].last !== m_last_word)
                        note_failure($sformatf("word %0d last: expected %0b got %0b",
                                               words_seen, digest_q[0].last, m_last_word));
                    void'(digest_q.pop_front());
                end
                words_seen++;
            end
            // stall-free stretch in the middle of the run
            m_ready <= (words_seen >= 80 && words_seen < 160) ||
                       ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_item(input logic [7:0] data, input logic has_byte, input logic ends,
                            input bit steady = 1'b0, input bit drain = 1'b0);
        hash_item_t it;
        it.data = data;
        it.has_byte = has_byte;
        it.ends = ends;
        it.steady = steady;
        it.drain = drain;
        byte_items.push_back(it);
    endtask

    // Random message: random bytes, some ignored noise words, end on a byte or alone
    task automatic queue_message(input int len, input bit steady, input bit drain);
        bit end_on_byte;
        bit first;
        end_on_byte = (len > 0) && $urandom_range(1);
        first = drain;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                add_item(8'($urandom), 1'b0, 1'b0, steady, first);
                first = 1'b0;
            end
            add_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1), steady, first);
            first = 1'b0;
            random_bytes_queued++;
        end
        if (!end_on_byte) add_item(8'($urandom), 1'b0, 1'b1, steady, first);
    endtask

    initial begin
        int len;
        int msg_no;
        int edge_lengths [10];
        edge_lengths = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
        restart_chain();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

        // Directed: empty message, idle words, short known message, byte extremes
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'hA5, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b1);
        add_item(8'hFF, 1'b1, 1'b1);
        add_item(8'h80, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1, 1'b1);

        // Random messages, lengths biased to the padding boundaries
        msg_no = 0;
        while (random_bytes_queued < RANDOM_BYTES) begin
            if ($urandom_range(9) < 3) len = edge_lengths[$urandom_range(9)];
            else len = $urandom_range(40);
            queue_message(len, msg_no == 3 || msg_no == 4, msg_no == 2);
            msg_no++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while ((byte_items.size() != 0 || s_valid || digest_q.size() != 0) &&
               cycle_count < CYCLE_LIMIT)
            @(negedge aclk);
        timed_out = (cycle_count >= CYCLE_LIMIT);
        if (!timed_out) repeat (TAIL_CYCLES) @(negedge aclk);

        if (timed_out) $display("Timed out after %0d cycles", cycle_count);
        if (digest_q.size() != 0) begin
            $display("%0d digest words never arrived", digest_q.size());
            failures += digest_q.size();
        end
        $display("Hashed %0d messages (%0d bytes, %0d blocks) from %0d input words;",
                 messages_done, bytes_taken, blocks_done, items_taken);
        $display("checked %0d digest words, %0d mismatches", words_seen, failures);
        if (!timed_out && failures == 0)
            $display("sha256_message_hasher regression: pass");
        else
            $display("sha256_message_hasher regression: fail");
        $finish;
    end

endmodule
